// File: rtl/tzr_pkg.sv
`default_nettype none
package tzr_pkg;

  // Input operation codes
  localparam logic [1:0] OP_VTX = 2'd0;
  localparam logic [1:0] OP_WR  = 2'd1;
  localparam logic [1:0] OP_RD  = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  // Light vector, Q2.14
  localparam logic signed [15:0] LIGHT_X = -16'sd6780;
  localparam logic signed [15:0] LIGHT_Y = 16'sd11300;
  localparam logic signed [15:0] LIGHT_Z = 16'sd9793;

  // Toon scale factors in percent
  localparam logic [6:0] TOON_HI  = 7'd105;
  localparam logic [6:0] TOON_MID = 7'd81;
  localparam logic [6:0] TOON_LO  = 7'd46;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [31:0] z;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } vtx_t;

  // Product groups of the shared multiply-accumulate unit
  typedef enum logic [3:0] {
    MG_DEN, MG_UN, MG_TN, MG_Z, MG_NX, MG_NY, MG_NZ, MG_DOT, MG_LEN
  } mac_grp_e;

  // Capture targets
  typedef enum logic [3:0] {
    CAP_NONE, CAP_DEN, CAP_UN, CAP_TN, CAP_WU, CAP_WT, CAP_Z,
    CAP_NX, CAP_NY, CAP_NZ, CAP_DOT, CAP_LEN
  } cap_e;

  typedef struct packed {
    logic     hold_a;
    logic     hold_b;
    logic     load_c;
    logic     pix_wr;
    logic     pix_rd;
    logic     mul_en;
    logic     acc_load;
    mac_grp_e grp;
    logic [1:0] term;
    cap_e     cap;
    logic     bbox;
    logic     first_px;
    logic     adv_x;
    logic     adv_y;
    logic     idx_calc;
    logic     zrd;
    logic     div_load;
    logic     div_src_t;
    logic     div_step;
    logic     sq_load;
    logic     sq_step;
    logic     shade;
    logic     shade_wr;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic bbox_empty;
    logic outside;
    logic z_fail;
    logic x_last;
    logic y_last;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/tzr_ctrl.sv
`default_nettype none
module tzr_ctrl
  import tzr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [1:0] op_i,
  input  wire sts_t       sts_i,
  output logic            busy_o,
  output logic            res_valid_o,
  output cmd_t            cmd_o
);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_READ  = 20'h00002,
    S_DEN   = 20'h00004,
    S_BBOX  = 20'h00008,
    S_UN    = 20'h00010,
    S_TN    = 20'h00020,
    S_TEST  = 20'h00040,
    S_DIVU  = 20'h00080,
    S_DIVT  = 20'h00100,
    S_DEPTH = 20'h00200,
    S_ZCMP  = 20'h00400,
    S_NX    = 20'h00800,
    S_NY    = 20'h01000,
    S_NZ    = 20'h02000,
    S_DOT   = 20'h04000,
    S_LEN   = 20'h08000,
    S_SQRT  = 20'h10000,
    S_SHADE = 20'h20000,
    S_WRITE = 20'h40000,
    S_NEXT  = 20'h80000
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] vcnt_q, vcnt_d;

  logic       mac_en;
  logic [4:0] mac_n;
  mac_grp_e   mac_grp;
  cap_e       mac_cap;
  state_e     mac_next;

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q + 5'd1;
    vcnt_d      = vcnt_q;
    cmd_o       = '0;
    res_valid_o = 1'b0;
    mac_en      = 1'b0;
    mac_n       = 5'd3;
    mac_grp     = MG_DEN;
    mac_cap     = CAP_NONE;
    mac_next    = S_IDLE;
    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (start_i) begin
          unique case (op_i)
            OP_VTX: begin
              if (vcnt_q == 2'd2) begin
                cmd_o.load_c = 1'b1;
                vcnt_d       = '0;
                state_d      = S_DEN;
              end else begin
                cmd_o.hold_a = (vcnt_q == 2'd0);
                cmd_o.hold_b = (vcnt_q != 2'd0);
                vcnt_d       = vcnt_q + 2'd1;
              end
            end
            OP_WR: cmd_o.pix_wr = 1'b1;
            OP_RD: begin
              cmd_o.pix_rd = 1'b1;
              state_d      = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        res_valid_o = 1'b1;
        state_d     = S_IDLE;
      end
      S_DEN: begin
        mac_en   = 1'b1;
        mac_n    = 5'd2;
        mac_grp  = MG_DEN;
        mac_cap  = CAP_DEN;
        mac_next = sts_i.den_zero ? S_IDLE : S_BBOX;
      end
      S_BBOX: begin
        if (cnt_q == 5'd0) begin
          cmd_o.bbox = 1'b1;
        end else begin
          cnt_d = '0;
          if (sts_i.bbox_empty) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.first_px = 1'b1;
            state_d        = S_UN;
          end
        end
      end
      S_UN: begin
        cmd_o.idx_calc = (cnt_q == 5'd0);
        mac_en   = 1'b1;
        mac_n    = 5'd2;
        mac_grp  = MG_UN;
        mac_cap  = CAP_UN;
        mac_next = S_TN;
      end
      S_TN: begin
        mac_en   = 1'b1;
        mac_n    = 5'd2;
        mac_grp  = MG_TN;
        mac_cap  = CAP_TN;
        mac_next = S_TEST;
      end
      S_TEST: begin
        cnt_d   = '0;
        state_d = sts_i.outside ? S_NEXT : S_DIVU;
      end
      S_DIVU, S_DIVT: begin
        cmd_o.div_src_t = (state_q == S_DIVT);
        if (cnt_q == 5'd0) begin
          cmd_o.div_load = 1'b1;
        end else if (cnt_q <= 5'd17) begin
          cmd_o.div_step = 1'b1;
        end else begin
          cmd_o.cap = (state_q == S_DIVT) ? CAP_WT : CAP_WU;
          cnt_d     = '0;
          state_d   = (state_q == S_DIVT) ? S_DEPTH : S_DIVT;
        end
      end
      S_DEPTH: begin
        cmd_o.zrd = (cnt_q == 5'd0);
        mac_en   = 1'b1;
        mac_grp  = MG_Z;
        mac_cap  = CAP_Z;
        mac_next = S_ZCMP;
      end
      S_ZCMP: begin
        cnt_d   = '0;
        state_d = sts_i.z_fail ? S_NEXT : S_NX;
      end
      S_NX: begin
        mac_en   = 1'b1;
        mac_grp  = MG_NX;
        mac_cap  = CAP_NX;
        mac_next = S_NY;
      end
      S_NY: begin
        mac_en   = 1'b1;
        mac_grp  = MG_NY;
        mac_cap  = CAP_NY;
        mac_next = S_NZ;
      end
      S_NZ: begin
        mac_en   = 1'b1;
        mac_grp  = MG_NZ;
        mac_cap  = CAP_NZ;
        mac_next = S_DOT;
      end
      S_DOT: begin
        mac_en   = 1'b1;
        mac_grp  = MG_DOT;
        mac_cap  = CAP_DOT;
        mac_next = S_LEN;
      end
      S_LEN: begin
        mac_en   = 1'b1;
        mac_grp  = MG_LEN;
        mac_cap  = CAP_LEN;
        mac_next = S_SQRT;
      end
      S_SQRT: begin
        if (cnt_q == 5'd0) begin
          cmd_o.sq_load = 1'b1;
        end else if (cnt_q <= 5'd16) begin
          cmd_o.sq_step = 1'b1;
        end else begin
          cnt_d   = '0;
          state_d = S_SHADE;
        end
      end
      S_SHADE: begin
        cmd_o.shade = 1'b1;
        cnt_d       = '0;
        state_d     = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.shade_wr = 1'b1;
        cnt_d          = '0;
        state_d        = S_NEXT;
      end
      S_NEXT: begin
        cnt_d = '0;
        if (!sts_i.x_last) begin
          cmd_o.adv_x = 1'b1;
          state_d     = S_UN;
        end else if (!sts_i.y_last) begin
          cmd_o.adv_y = 1'b1;
          state_d     = S_UN;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        cnt_d   = '0;
      end
    endcase

    // issue one product a cycle, capture once the last sum has landed
    if (mac_en) begin
      cmd_o.grp      = mac_grp;
      cmd_o.term     = cnt_q[1:0];
      cmd_o.mul_en   = (cnt_q < mac_n);
      cmd_o.acc_load = (cnt_q == 5'd0);
      if (cnt_q == mac_n + 5'd1) begin
        cmd_o.cap = mac_cap;
        cnt_d     = '0;
        state_d   = mac_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      vcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      vcnt_q  <= vcnt_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tzr_dpath.sv
`default_nettype none
module tzr_dpath
  import tzr_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  output sts_t                    sts_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [8:0]         cfg_data_i,
  input  wire logic signed [23:0] pos_x_i,
  input  wire logic signed [23:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [15:0] norm_x_i,
  input  wire logic signed [15:0] norm_y_i,
  input  wire logic signed [15:0] norm_z_i,
  input  wire logic [15:0]        pixel_index_i,
  input  wire logic signed [31:0] depth_in_i,
  input  wire logic [7:0]         red_in_i,
  input  wire logic [7:0]         green_in_i,
  input  wire logic [7:0]         blue_in_i,
  output logic signed [31:0]      depth_out_o,
  output logic [7:0]              red_out_o,
  output logic [7:0]              green_out_o,
  output logic [7:0]              blue_out_o
);

  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_RED    = 3'd2;
  localparam logic [2:0] CFG_GREEN  = 3'd3;
  localparam logic [2:0] CFG_BLUE   = 3'd4;

  function automatic logic signed [24:0] sx24(input logic [23:0] v);
    return $signed({v[23], v});
  endfunction

  function automatic logic [7:0] toon(input logic [7:0] col, input logic [6:0] k);
    logic [14:0] v;
    logic [27:0] q;
    v = 15'(col) * 15'(k);
    q = 28'(v) * 28'd5243;
    return (q[27:19] > 9'd255) ? 8'd255 : q[26:19];
  endfunction

  // configuration
  logic [8:0] fw_q, fh_q;
  logic [7:0] fr_q, fg_q, fb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= 9'd256;
      fh_q <= 9'd256;
      fr_q <= 8'd255;
      fg_q <= 8'd255;
      fb_q <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:  fw_q <= cfg_data_i;
        CFG_HEIGHT: fh_q <= cfg_data_i;
        CFG_RED:    fr_q <= cfg_data_i[7:0];
        CFG_GREEN:  fg_q <= cfg_data_i[7:0];
        CFG_BLUE:   fb_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [8:0] w_eff, h_eff;
  always_comb begin
    if (fw_q == 9'd0)                w_eff = 9'd1;
    else if (32'(fw_q) > MAX_WIDTH)  w_eff = 9'(MAX_WIDTH);
    else                             w_eff = fw_q;
    if (fh_q == 9'd0)                h_eff = 9'd1;
    else if (32'(fh_q) > MAX_HEIGHT) h_eff = 9'(MAX_HEIGHT);
    else                             h_eff = fh_q;
  end

  // vertices
  vtx_t vin, va_q, vb_q, vc_q;
  assign vin = '{x: pos_x_i, y: pos_y_i, z: pos_z_i,
                 nx: norm_x_i, ny: norm_y_i, nz: norm_z_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_a) va_q <= vin;
    if (cmd_i.hold_b) vb_q <= vin;
    if (cmd_i.load_c) vc_q <= vin;
  end

  logic signed [24:0] dyb, dxcb, dxa, dya, dyca;
  assign dyb  = sx24(vb_q.y) - sx24(vc_q.y);
  assign dxcb = sx24(vc_q.x) - sx24(vb_q.x);
  assign dxa  = sx24(va_q.x) - sx24(vc_q.x);
  assign dya  = sx24(va_q.y) - sx24(vc_q.y);
  assign dyca = sx24(vc_q.y) - sx24(va_q.y);

  // pixel walk
  logic [8:0]         x_q, y_q;
  logic signed [16:0] x0_q, x1_q, y0_q, y1_q;
  logic [17:0]        idx_q;
  logic signed [25:0] px, py;

  assign px = $signed({9'b0, x_q, 8'h80}) - $signed({{2{vc_q.x[23]}}, vc_q.x});
  assign py = $signed({9'b0, y_q, 8'h80}) - $signed({{2{vc_q.y[23]}}, vc_q.y});

  logic signed [23:0] minx, maxx, miny, maxy;
  logic signed [24:0] maxx_r, maxy_r;
  logic signed [16:0] bx0, bx1, by0, by1, wlim, hlim;

  always_comb begin
    minx = ($signed(va_q.x) < $signed(vb_q.x)) ? va_q.x : vb_q.x;
    minx = ($signed(minx) < $signed(vc_q.x)) ? minx : vc_q.x;
    maxx = ($signed(va_q.x) > $signed(vb_q.x)) ? va_q.x : vb_q.x;
    maxx = ($signed(maxx) > $signed(vc_q.x)) ? maxx : vc_q.x;
    miny = ($signed(va_q.y) < $signed(vb_q.y)) ? va_q.y : vb_q.y;
    miny = ($signed(miny) < $signed(vc_q.y)) ? miny : vc_q.y;
    maxy = ($signed(va_q.y) > $signed(vb_q.y)) ? va_q.y : vb_q.y;
    maxy = ($signed(maxy) > $signed(vc_q.y)) ? maxy : vc_q.y;
    maxx_r = sx24(maxx) + 25'sd255;
    maxy_r = sx24(maxy) + 25'sd255;
    wlim = $signed({8'b0, w_eff - 9'd1});
    hlim = $signed({8'b0, h_eff - 9'd1});
    bx0 = $signed({minx[23], minx[23:8]});
    by0 = $signed({miny[23], miny[23:8]});
    bx1 = maxx_r[24:8];
    by1 = maxy_r[24:8];
    if (bx0 < 17'sd0) bx0 = '0;
    if (by0 < 17'sd0) by0 = '0;
    if (bx1 > wlim) bx1 = wlim;
    if (by1 > hlim) by1 = hlim;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bbox) begin
      x0_q <= bx0;
      x1_q <= bx1;
      y0_q <= by0;
      y1_q <= by1;
    end
    if (cmd_i.first_px) begin
      x_q <= x0_q[8:0];
      y_q <= y0_q[8:0];
    end else if (cmd_i.adv_x) begin
      x_q <= x_q + 9'd1;
    end else if (cmd_i.adv_y) begin
      x_q <= x0_q[8:0];
      y_q <= y_q + 9'd1;
    end
    if (cmd_i.idx_calc) idx_q <= 18'(y_q) * 18'(w_eff) + 18'(x_q);
  end

  // shared multiply-accumulate
  logic [16:0]        wu_q, wt_q, ws;
  logic [17:0]        ws_full;
  logic signed [15:0] n0_q, n1_q, n2_q;
  logic signed [25:0] a_sel;
  logic signed [31:0] b_sel;
  logic signed [57:0] prod, p_q;
  logic signed [59:0] acc_q;
  logic               pv_q, pl_q;

  assign ws_full = 18'h10000 - 18'(wu_q) - 18'(wt_q);
  assign ws      = ws_full[16:0];

  function automatic logic signed [25:0] wsel(input logic [1:0] t, input logic [16:0] u,
                                              input logic [16:0] v, input logic [16:0] s);
    unique case (t)
      2'd0:    return $signed({9'b0, u});
      2'd1:    return $signed({9'b0, v});
      default: return $signed({9'b0, s});
    endcase
  endfunction

  function automatic logic signed [31:0] nsel(input logic [1:0] t, input logic [15:0] u,
                                              input logic [15:0] v, input logic [15:0] s);
    unique case (t)
      2'd0:    return $signed({{16{u[15]}}, u});
      2'd1:    return $signed({{16{v[15]}}, v});
      default: return $signed({{16{s[15]}}, s});
    endcase
  endfunction

  always_comb begin
    a_sel = '0;
    b_sel = '0;
    unique case (cmd_i.grp)
      MG_DEN: begin
        a_sel = (cmd_i.term == 2'd0) ? {dyb[24], dyb} : {dxcb[24], dxcb};
        b_sel = (cmd_i.term == 2'd0) ? 32'(dxa) : 32'(dya);
      end
      MG_UN: begin
        a_sel = (cmd_i.term == 2'd0) ? {dyb[24], dyb} : {dxcb[24], dxcb};
        b_sel = (cmd_i.term == 2'd0) ? 32'(px) : 32'(py);
      end
      MG_TN: begin
        a_sel = (cmd_i.term == 2'd0) ? {dyca[24], dyca} : {dxa[24], dxa};
        b_sel = (cmd_i.term == 2'd0) ? 32'(px) : 32'(py);
      end
      MG_Z: begin
        a_sel = wsel(cmd_i.term, wu_q, wt_q, ws);
        unique case (cmd_i.term)
          2'd0:    b_sel = va_q.z;
          2'd1:    b_sel = vb_q.z;
          default: b_sel = vc_q.z;
        endcase
      end
      MG_NX: begin
        a_sel = wsel(cmd_i.term, wu_q, wt_q, ws);
        b_sel = nsel(cmd_i.term, va_q.nx, vb_q.nx, vc_q.nx);
      end
      MG_NY: begin
        a_sel = wsel(cmd_i.term, wu_q, wt_q, ws);
        b_sel = nsel(cmd_i.term, va_q.ny, vb_q.ny, vc_q.ny);
      end
      MG_NZ: begin
        a_sel = wsel(cmd_i.term, wu_q, wt_q, ws);
        b_sel = nsel(cmd_i.term, va_q.nz, vb_q.nz, vc_q.nz);
      end
      MG_DOT: begin
        a_sel = 26'(nsel(cmd_i.term, n0_q, n1_q, n2_q));
        b_sel = nsel(cmd_i.term, LIGHT_X, LIGHT_Y, LIGHT_Z);
      end
      MG_LEN: begin
        a_sel = 26'(nsel(cmd_i.term, n0_q, n1_q, n2_q));
        b_sel = nsel(cmd_i.term, n0_q, n1_q, n2_q);
      end
      default: ;
    endcase
  end

  assign prod = a_sel * b_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      pl_q <= 1'b0;
    end else begin
      pv_q <= cmd_i.mul_en;
      pl_q <= cmd_i.acc_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) p_q <= prod;
    if (pv_q) acc_q <= pl_q ? 60'(p_q) : acc_q + 60'(p_q);
  end

  // captured values
  logic signed [52:0] acc53, den_q, un_q, tn_q;
  logic signed [54:0] sn;
  logic               sg_q;
  logic signed [31:0] z_q;
  logic signed [32:0] dot_q;
  logic [31:0]        len2_q;

  assign acc53 = acc_q[52:0];
  assign sn = 55'(den_q) - 55'(un_q) - 55'(tn_q);

  // weight divider, one quotient bit a cycle
  logic [52:0] dr_q, dr_sh, dr_sub;
  logic [16:0] dq_q;
  logic        dfirst_q, dge;

  assign dr_sh  = dfirst_q ? dr_q : {dr_q[51:0], 1'b0};
  assign dge    = (dr_sh >= den_q);
  assign dr_sub = dr_sh - den_q;

  // integer square root, one radicand at a time, result built bit by bit from the top bit pair down
  logic [31:0] sv_q, sres_q, sbit_q;
  logic [32:0] strial;
  assign strial = 33'(sres_q) + 33'(sbit_q);

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.cap)
      CAP_DEN: begin
        sg_q  <= acc53[52];
        den_q <= acc53[52] ? -acc53 : acc53;
      end
      CAP_UN:  un_q   <= sg_q ? -acc53 : acc53;
      CAP_TN:  tn_q   <= sg_q ? -acc53 : acc53;
      CAP_WU:  wu_q   <= dq_q;
      CAP_WT:  wt_q   <= dq_q;
      CAP_Z:   z_q    <= acc_q[47:16];
      CAP_NX:  n0_q   <= acc_q[31:16];
      CAP_NY:  n1_q   <= acc_q[31:16];
      CAP_NZ:  n2_q   <= acc_q[31:16];
      CAP_DOT: dot_q  <= acc_q[32:0];
      CAP_LEN: len2_q <= acc_q[31:0];
      default: ;
    endcase
    if (cmd_i.div_load) begin
      dr_q     <= cmd_i.div_src_t ? tn_q : un_q;
      dq_q     <= '0;
      dfirst_q <= 1'b1;
    end else if (cmd_i.div_step) begin
      dr_q     <= dge ? dr_sub : dr_sh;
      dq_q     <= {dq_q[15:0], dge};
      dfirst_q <= 1'b0;
    end
    if (cmd_i.sq_load) begin
      sv_q   <= len2_q;
      sres_q <= '0;
      sbit_q <= 32'h4000_0000;
    end else if (cmd_i.sq_step) begin
      if (33'(sv_q) >= strial) begin
        sv_q   <= sv_q - strial[31:0];
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end

  // shade level
  logic signed [37:0] dot_x, len_x;
  logic [6:0]         k_q;
  assign dot_x = 38'(dot_q);
  assign len_x = $signed({22'b0, sres_q[15:0]});

  always_ff @(posedge clk_i) begin
    if (cmd_i.shade) begin
      if (dot_x * 38'sd5 > len_x * 38'sd49152)      k_q <= TOON_HI;
      else if (dot_x * 38'sd20 > len_x * 38'sd16384) k_q <= TOON_MID;
      else                                          k_q <= TOON_LO;
    end
  end

  // depth and color stores
  logic [31:0] depth_mem [STORE_SIZE];
  logic [23:0] color_mem [STORE_SIZE];
  logic        in_range, mem_we, mem_re;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0] wr_depth, rd_depth_q;
  logic [23:0] wr_color, rd_color_q;
  logic        oob_q;

  assign in_range = (32'(pixel_index_i) < STORE_SIZE);
  assign mem_we   = (cmd_i.pix_wr && in_range) || cmd_i.shade_wr;
  assign mem_re   = cmd_i.pix_rd || cmd_i.zrd;
  assign wr_addr  = cmd_i.shade_wr ? AW'(idx_q) : AW'(pixel_index_i);
  assign rd_addr  = cmd_i.zrd ? AW'(idx_q) : AW'(pixel_index_i);
  assign wr_depth = cmd_i.shade_wr ? z_q : depth_in_i;
  assign wr_color = cmd_i.shade_wr ? {toon(fr_q, k_q), toon(fg_q, k_q), toon(fb_q, k_q)}
                                   : {red_in_i, green_in_i, blue_in_i};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      depth_mem[wr_addr] <= wr_depth;
      color_mem[wr_addr] <= wr_color;
    end
    if (mem_re) begin
      rd_depth_q <= depth_mem[rd_addr];
      rd_color_q <= color_mem[rd_addr];
    end
    if (cmd_i.pix_rd) oob_q <= !in_range;
  end

  assign depth_out_o = oob_q ? '0 : rd_depth_q;
  assign red_out_o   = oob_q ? '0 : rd_color_q[23:16];
  assign green_out_o = oob_q ? '0 : rd_color_q[15:8];
  assign blue_out_o  = oob_q ? '0 : rd_color_q[7:0];

  // status
  assign sts_o.den_zero   = (acc_q == '0);
  assign sts_o.bbox_empty = (x0_q > x1_q) || (y0_q > y1_q);
  assign sts_o.outside    = un_q[52] || tn_q[52] || sn[54];
  assign sts_o.z_fail     = (z_q <= $signed(rd_depth_q));
  assign sts_o.x_last     = (x_q == x1_q[8:0]);
  assign sts_o.y_last     = (y_q == y1_q[8:0]);

endmodule
`default_nettype wire

// File: rtl/triangle_zbuffer_toon_raster_unit.sv
// The first two vertices and pixel writes are taken in idle without raising busy_o; a read
// request puts its result on res_valid_o in the cycle after acceptance, busy meanwhile.
// A closing vertex sets up the area and then the box, then per pixel tests the edges and,
// when inside, divides out two weights and tests depth, and when it wins shades and writes;
// the work runs on the shared multiply-accumulate, 17-step divider and 16-step root.
// Reset inits controller, vertex count and config; most datapath regs and stores are not reset.
`default_nettype none
module triangle_zbuffer_toon_raster_unit
  import tzr_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         op_i,
  input  wire logic signed [23:0] pos_x_i,
  input  wire logic signed [23:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [15:0] norm_x_i,
  input  wire logic signed [15:0] norm_y_i,
  input  wire logic signed [15:0] norm_z_i,
  input  wire logic [15:0]        pixel_index_i,
  input  wire logic signed [31:0] depth_in_i,
  input  wire logic [7:0]         red_in_i,
  input  wire logic [7:0]         green_in_i,
  input  wire logic [7:0]         blue_in_i,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [8:0]         cfg_data_i,
  output logic                    res_valid_o,
  output logic signed [31:0]      depth_out_o,
  output logic [7:0]              red_out_o,
  output logic [7:0]              green_out_o,
  output logic [7:0]              blue_out_o
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequence requests: hold vertices, walk the box, step the shared units
  tzr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .op_i        (op_i),
    .sts_i       (sts),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .cmd_o       (cmd)
  );

  // hold vertices, stores, multiply-accumulate, divider, root and shading
  tzr_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .norm_x_i      (norm_x_i),
    .norm_y_i      (norm_y_i),
    .norm_z_i      (norm_z_i),
    .pixel_index_i (pixel_index_i),
    .depth_in_i    (depth_in_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .depth_out_o   (depth_out_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o)
  );

endmodule
`default_nettype wire
